@@ rtl/bezier_curve_evaluator_assert.svh @@
// Assertion macros shared by the Bezier evaluator checker.
`ifndef BEZIER_CURVE_EVALUATOR_ASSERT_SVH
`define BEZIER_CURVE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bce check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define BCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bce check failed");

`endif

@@ rtl/bce_pkg.sv @@
// Types and constants of the Bezier curve evaluator.
package bce_pkg;

    localparam int CW             = 32;
    localparam int TF             = 16;
    localparam int T_W            = TF + 1;
    localparam int NUM_CH         = 6;
    localparam int PC_W           = 5;
    localparam int IDX_W          = 4;
    localparam int SEG_W          = 6;
    localparam int MAX_POINTS_DEF   = 16;
    localparam int MAX_SEGMENTS_DEF = 63;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_EVAL  = 2'd1;
    localparam cmd_t CMD_DERIV = 2'd2;
    localparam cmd_t CMD_DISC  = 2'd3;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IDX_W-1:0]         point_index;
        logic signed [CW-1:0]     in_pos_x;
        logic signed [CW-1:0]     in_pos_y;
        logic signed [CW-1:0]     in_pos_z;
        logic signed [CW-1:0]     in_col_r;
        logic signed [CW-1:0]     in_col_g;
        logic signed [CW-1:0]     in_col_b;
        logic [T_W-1:0]           param_t;
        logic [SEG_W-1:0]         segment_count;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0]     out_pos_x;
        logic signed [CW-1:0]     out_pos_y;
        logic signed [CW-1:0]     out_pos_z;
        logic signed [CW-1:0]     out_col_r;
        logic signed [CW-1:0]     out_col_g;
        logic signed [CW-1:0]     out_col_b;
        logic                     last_point;
    } out_item_t;

endpackage

@@ rtl/bezier_curve_evaluator.sv @@
// Bezier curve evaluator: de Casteljau over stored control points, one shared lerp unit.
// Each result evaluates six channels one after another; a derivative works on point differences
// and is zero with one point. The single lerp multiplier walks the triangle one element a cycle,
// draining between levels, and the result is then offered on m. Discretize first divides 2^TF by
// the segment count; a load writes one point row. Throughput: one transaction at a time.
// Reset (aresetn low, synchronous): sequencer idle, point_count 1, no result pending.
module bezier_curve_evaluator import bce_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PC_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = CW + 1;          // scratch width, holds point differences
    localparam int DW    = SW + 1;          // difference of two scratch values
    localparam int PW    = DW + T_W + 1;    // lerp product
    localparam int SCW   = SW + NW + 1;     // degree-scaled result
    localparam int CH_W  = $clog2(NUM_CH);
    localparam int ROW_W = NUM_CH * CW;
    localparam int RW    = SEG_W + 1;       // divider remainder
    localparam int CNT_W = $clog2(T_W);
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << TF;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_PASS  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_SAT   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // One pass of the scratch walk: copy points, difference points, one lerp level, fetch s[0].
    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_DIFF,
        MODE_LERP,
        MODE_FETCH
    } pass_mode_t;

    state_t                 state_reg, state_next;
    pass_mode_t             mode_reg, mode_next;
    logic [PC_W-1:0]        pc_reg, pc_next;
    logic                   deriv_reg, deriv_next;
    logic                   disc_reg, disc_next;
    logic [T_W-1:0]         t_reg, t_next;
    logic [SEG_W-1:0]       segs_reg, segs_next;
    logic [SEG_W-1:0]       samp_reg, samp_next;
    logic [T_W-1:0]         qstep_reg, qstep_next;
    logic [RW-1:0]          rstep_reg, rstep_next;
    logic [RW-1:0]          trem_reg, trem_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          len_reg, len_next;
    logic [NW-1:0]          j_reg, j_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic                   last_reg, last_next;
    logic                   p1_vld_reg, p1_vld_next;
    logic [NW-1:0]          p1_idx_reg;
    logic                   p2_vld_reg, p2_vld_next;
    logic [NW-1:0]          p2_idx_reg;
    logic signed [SW-1:0]   prev_reg;
    logic signed [SW-1:0]   a_reg, a_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [SW-1:0]   r_reg, r_next;
    logic signed [SCW-1:0]  scaled_reg;
    logic signed [CW-1:0]   res_reg [NUM_CH];

    logic                   s_fire;
    logic                   pt_we;
    logic [ROW_W-1:0]       pt_wdata;
    logic [ROW_W-1:0]       pt_rdata;
    logic                   sc_we;
    logic [AW-1:0]          sc_waddr;
    logic signed [SW-1:0]   sc_wdata;
    logic [SW-1:0]          sc_rdata;
    logic signed [SW-1:0]   src;
    logic signed [DW-1:0]   diff;
    logic [NW-1:0]          n_in;
    logic [SEG_W-1:0]       segs_in;
    logic [T_W-1:0]         t_in;
    logic [RW-1:0]          div_sh;
    logic [NW-1:0]          rem_pts;
    logic [T_W-1:0]         t_adv;
    logic [RW-1:0]          trem_adv;
    logic [NW-1:0]          scale_k;
    logic signed [SCW-1:0]  scaled_next;
    logic signed [CW-1:0]   sat_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    // Control point store, one row per point, six channels side by side.
    assign pt_we    = s_fire && (s_data.cmd == CMD_LOAD) && (int'(s_data.point_index) < MAX_POINTS);
    assign pt_wdata = {s_data.in_col_b, s_data.in_col_g, s_data.in_col_r,
                       s_data.in_pos_z, s_data.in_pos_y, s_data.in_pos_x};

    bce_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (AW'(s_data.point_index)),
        .wdata (pt_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (pt_rdata)
    );

    // Working row of one channel, rewritten in place level by level.
    bce_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_scratch_ram (
        .aclk  (aclk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (sc_rdata)
    );

    // Clamp the command fields: point count, segment count, t.
    always_comb begin
        if (pc_reg == '0) begin
            n_in = NW'(1);
        end else if (int'(pc_reg) > MAX_POINTS) begin
            n_in = NW'(MAX_POINTS);
        end else begin
            n_in = NW'(pc_reg);
        end
        if (s_data.segment_count == '0) begin
            segs_in = SEG_W'(1);
        end else if (int'(s_data.segment_count) > MAX_SEGMENTS) begin
            segs_in = SEG_W'(MAX_SEGMENTS);
        end else begin
            segs_in = s_data.segment_count;
        end
        t_in = (s_data.param_t > T_ONE) ? T_ONE : s_data.param_t;
    end

    // Stage one of the lerp unit: operand select, difference, multiply.
    always_comb begin
        if (mode_reg == MODE_COPY || mode_reg == MODE_DIFF) begin
            src = SW'($signed(pt_rdata[ch_reg*CW +: CW]));
        end else begin
            src = $signed(sc_rdata);
        end
        diff      = DW'(src) - DW'(prev_reg);
        prod_next = '0;
        unique case (mode_reg)
            MODE_COPY: begin
                a_next = src;
            end
            MODE_DIFF: begin
                a_next = SW'(diff);
            end
            MODE_LERP: begin
                a_next    = prev_reg;
                prod_next = PW'(diff * $signed({1'b0, t_reg}));
            end
            default: begin
                a_next = src;
            end
        endcase
    end

    // Stage two: a + floor(d * t), write back.
    assign sc_wdata = a_reg + SW'(prod_reg >>> TF);
    assign sc_waddr = (mode_reg == MODE_COPY) ? p2_idx_reg[AW-1:0] : AW'(p2_idx_reg - NW'(1));
    assign sc_we    = p2_vld_reg &&
                      ((mode_reg == MODE_COPY) || (p2_idx_reg != '0));

    // Degree scale and saturation.
    assign scale_k     = deriv_reg ? (n_reg - NW'(1)) : NW'(1);
    assign scaled_next = SCW'(r_reg * $signed({1'b0, scale_k}));

    always_comb begin
        if (scaled_reg > $signed(SCW'({1'b0, {(CW-1){1'b1}}}))) begin
            sat_val = {1'b0, {(CW-1){1'b1}}};
        end else if (scaled_reg < -$signed(SCW'({1'b0, {(CW-1){1'b1}}})) - SCW'(1)) begin
            sat_val = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_val = CW'(scaled_reg);
        end
    end

    // Next sample parameter for discretize: t += 2^TF/segs with remainder carry.
    always_comb begin
        t_adv    = t_reg + qstep_reg;
        trem_adv = trem_reg + rstep_reg;
        if (trem_adv >= RW'(segs_reg)) begin
            trem_adv = trem_adv - RW'(segs_reg);
            t_adv    = t_adv + T_W'(1);
        end
        div_sh = {rstep_reg[RW-2:0], (div_cnt_reg == '0)};
    end

    // Points left after the pass that just drained.
    assign rem_pts = (mode_reg == MODE_COPY) ? len_reg : (len_reg - NW'(1));

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        pc_next      = pc_reg;
        deriv_next   = deriv_reg;
        disc_next    = disc_reg;
        t_next       = t_reg;
        segs_next    = segs_reg;
        samp_next    = samp_reg;
        qstep_next   = qstep_reg;
        rstep_next   = rstep_reg;
        trem_next    = trem_reg;
        div_cnt_next = div_cnt_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        j_next       = j_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        r_next       = r_reg;
        p1_vld_next  = 1'b0;
        p2_vld_next  = p1_vld_reg && (mode_reg != MODE_FETCH);

        if (cfg_valid && cfg_ready) begin
            pc_next = cfg_data;
        end
        if (p1_vld_reg && mode_reg == MODE_FETCH) begin
            r_next = src;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.cmd != CMD_LOAD) begin
                    n_next     = n_in;
                    ch_next    = '0;
                    deriv_next = (s_data.cmd == CMD_DERIV);
                    disc_next  = (s_data.cmd == CMD_DISC);
                    if (s_data.cmd == CMD_DISC) begin
                        // Divide 2^TF by the segment count once, then step.
                        segs_next    = segs_in;
                        samp_next    = '0;
                        t_next       = '0;
                        trem_next    = '0;
                        qstep_next   = '0;
                        rstep_next   = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end else begin
                        t_next     = t_in;
                        state_next = ST_START;
                    end
                end
            end
            ST_DIV: begin
                if (div_sh >= RW'(segs_reg)) begin
                    rstep_next = div_sh - RW'(segs_reg);
                    qstep_next = {qstep_reg[T_W-2:0], 1'b1};
                end else begin
                    rstep_next = div_sh;
                    qstep_next = {qstep_reg[T_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(T_W - 1)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                j_next = '0;
                if (deriv_reg && n_reg == NW'(1)) begin
                    // Single point: derivative is zero, skip the walk.
                    r_next     = '0;
                    state_next = ST_SCALE;
                end else begin
                    mode_next  = deriv_reg ? MODE_DIFF : MODE_COPY;
                    len_next   = n_reg;
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                p1_vld_next = 1'b1;
                if (j_reg == len_reg - NW'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + NW'(1);
                end
            end
            ST_DRAIN: begin
                if (!p1_vld_reg && !p2_vld_reg) begin
                    j_next = '0;
                    if (mode_reg == MODE_FETCH) begin
                        state_next = ST_SCALE;
                    end else if (rem_pts >= NW'(2)) begin
                        mode_next  = MODE_LERP;
                        len_next   = rem_pts;
                        state_next = ST_PASS;
                    end else begin
                        mode_next  = MODE_FETCH;
                        len_next   = NW'(1);
                        state_next = ST_PASS;
                    end
                end
            end
            ST_SCALE: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                if (ch_reg == CH_W'(NUM_CH - 1)) begin
                    last_next  = !disc_reg || (samp_reg == segs_reg);
                    state_next = ST_OUT;
                end else begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_START;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (disc_reg && samp_reg != segs_reg) begin
                        samp_next  = samp_reg + SEG_W'(1);
                        t_next     = t_adv;
                        trem_next  = trem_adv;
                        ch_next    = '0;
                        state_next = ST_START;
                    end else begin
                        samp_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pc_reg     <= PC_W'(1);
            samp_reg   <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            samp_reg   <= samp_next;
            p1_vld_reg <= p1_vld_next;
            p2_vld_reg <= p2_vld_next;
        end
    end

    // Datapath and sequencer working registers.
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        deriv_reg   <= deriv_next;
        disc_reg    <= disc_next;
        t_reg       <= t_next;
        segs_reg    <= segs_next;
        qstep_reg   <= qstep_next;
        rstep_reg   <= rstep_next;
        trem_reg    <= trem_next;
        div_cnt_reg <= div_cnt_next;
        n_reg       <= n_next;
        len_reg     <= len_next;
        j_reg       <= j_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        r_reg       <= r_next;
        p1_idx_reg  <= j_reg;
        p2_idx_reg  <= p1_idx_reg;
        scaled_reg  <= scaled_next;
        if (p1_vld_reg) begin
            prev_reg <= src;
            a_reg    <= a_next;
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SAT) begin
            res_reg[ch_reg] <= sat_val;
        end
    end

    assign m_data.out_pos_x  = res_reg[0];
    assign m_data.out_pos_y  = res_reg[1];
    assign m_data.out_pos_z  = res_reg[2];
    assign m_data.out_col_r  = res_reg[3];
    assign m_data.out_col_g  = res_reg[4];
    assign m_data.out_col_b  = res_reg[5];
    assign m_data.last_point = last_reg;

endmodule

@@ rtl/bce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bce_checker.sv @@
// Port-level checker for the Bezier curve evaluator, bound to the top level.
`include "bezier_curve_evaluator_assert.svh"

module bce_checker import bce_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input in_item_t   s_data,
    input logic       m_valid,
    input logic       m_ready,
    input out_item_t  m_data,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `BCE_ASSERT_NOW(a_no_accept_while_result, m_valid, !s_ready)
    `BCE_ASSERT_NEXT(a_busy_after_eval, s_valid && s_ready && s_data.cmd != CMD_LOAD, !s_ready)
    `BCE_ASSERT_NEXT(a_result_gap, m_valid && m_ready, !m_valid)
    `BCE_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))
    `BCE_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (.*);
